/* hw/rtl/hsfc_pkg.sv */
`timescale 1ns / 1ps
// Package for the humidity sensor frame checker: constants, result type,
// the frame position enum and the CRC-8 and divide-by-65535 helpers.
// No dependencies.
package hsfc_pkg;

  // crc-8 as used by the sensor: polynomial 0x31, seed 0xff
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // error limit after reset
  localparam logic [7:0] LimitReset = 8'd50;
  localparam logic [7:0] ErrMax     = 8'd255;

  // conversion scales, all in hundredths
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumiScale  = 14'd10000;
  localparam logic [13:0] HumiMax    = 14'd10000;

  // item kinds on the input tuser bit
  localparam logic OpByte  = 1'b0;
  localparam logic OpFault = 1'b1;

  // frame status codes
  localparam logic StatusGood = 1'b0;
  localparam logic StatusBad  = 1'b1;

  // position of the next byte within the six byte frame
  typedef enum logic [2:0] {
    PosTempMsb = 3'd0,
    PosTempLsb = 3'd1,
    PosTempCrc = 3'd2,
    PosHumiMsb = 3'd3,
    PosHumiLsb = 3'd4,
    PosHumiCrc = 3'd5
  } hsfc_pos_e;

  // one result item
  typedef struct packed {
    logic              status;
    logic [15:0]       temp_sample;
    logic [15:0]       humi_sample;
    logic signed [14:0] temp_centi;
    logic [13:0]       humi_centi;
    logic [7:0]        error_count;
  } hsfc_result_t;

  // one byte through the crc, msb first, all eight shifts unrolled
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: (x + (x >> 16) + 1) >> 16
  function automatic logic [15:0] div65535(input logic [31:0] x);
    logic [32:0] s;
    s = {1'b0, x} + {17'b0, x[31:16]} + 33'd1;
    return s[31:16];
  endfunction

endpackage

/* hw/rtl/hsfc_conv.sv */
`timescale 1ns / 1ps
// Unit conversion of the raw temperature and humidity words into
// hundredths of a degree and of a percent. Uses hsfc_pkg.
module hsfc_conv
  import hsfc_pkg::*;
(
  input  logic [15:0]        temp_word_i,
  input  logic [15:0]        humi_word_i,
  output logic signed [14:0] temp_centi_o,
  output logic [13:0]        humi_centi_o
);

  logic [31:0] temp_prod;
  logic [31:0] humi_prod;
  logic [15:0] temp_quot;
  logic [15:0] humi_quot;
  logic [14:0] temp_diff;

  // scale, then divide by full scale through the reciprocal trick
  assign temp_prod = {16'b0, temp_word_i} * {17'b0, TempScale};
  assign humi_prod = {16'b0, humi_word_i} * {18'b0, HumiScale};
  assign temp_quot = div65535(temp_prod);
  assign humi_quot = div65535(humi_prod);

  // temperature offset, two's complement wrap into 15 bits
  assign temp_diff    = temp_quot[14:0] - TempOffset;
  assign temp_centi_o = signed'(temp_diff);

  // humidity clamp to full scale
  assign humi_centi_o = (humi_quot > {2'b0, HumiMax}) ? HumiMax : humi_quot[13:0];

endmodule

/* hw/rtl/hsfc_frame.sv */
`timescale 1ns / 1ps
// Frame tracker: byte position, running crc, assembled words and the
// error counter; builds the result on the sixth byte. Uses hsfc_pkg, hsfc_conv.
module hsfc_frame
  import hsfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         proc_en_i,
  input  logic         op_i,
  input  logic [7:0]   byte_i,
  input  logic [7:0]   error_limit_i,
  output logic         res_valid_o,
  output hsfc_result_t res_o
);

  hsfc_pos_e   pos_q, pos_d, pos_cur;
  logic [7:0]  crc_q, crc_d, crc_cur;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] humi_word_q, humi_word_d;
  logic        temp_good_q, temp_good_d;
  logic [7:0]  errs_q, errs_d, errs_cur, errs_inc;
  logic        limit_hit;
  logic        humi_good;
  logic        frame_good;

  logic signed [14:0] temp_centi;
  logic [13:0]        humi_centi;

  hsfc_conv u_conv (
    .temp_word_i  (temp_word_q),
    .humi_word_i  (humi_word_q),
    .temp_centi_o (temp_centi),
    .humi_centi_o (humi_centi)
  );

  // counter clear at the limit, checked before the item is used
  assign limit_hit = (errs_q >= error_limit_i);
  assign errs_cur  = limit_hit ? 8'd0 : errs_q;
  assign crc_cur   = limit_hit ? CrcInit : crc_q;
  assign errs_inc  = (errs_cur == ErrMax) ? ErrMax : errs_cur + 8'd1;
  assign humi_good = (crc_cur == byte_i);
  assign frame_good = temp_good_q && humi_good;

  // stray positions count as the first byte
  always_comb begin
    if (limit_hit || (pos_q > PosHumiCrc)) begin
      pos_cur = PosTempMsb;
    end else begin
      pos_cur = pos_q;
    end
  end

  // next state and result
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    humi_word_d = humi_word_q;
    temp_good_d = temp_good_q;
    errs_d      = errs_q;
    res_valid_o = 1'b0;

    res_o.status      = frame_good ? StatusGood : StatusBad;
    res_o.temp_sample = temp_word_q;
    res_o.humi_sample = humi_word_q;
    res_o.temp_centi  = temp_centi;
    res_o.humi_centi  = humi_centi;
    res_o.error_count = frame_good ? 8'd0 : errs_inc;

    if (proc_en_i) begin
      errs_d = errs_cur;
      crc_d  = crc_cur;
      pos_d  = pos_cur;
      if (op_i == OpFault) begin
        errs_d = errs_inc;
        pos_d  = PosTempMsb;
        crc_d  = CrcInit;
      end else begin
        unique case (pos_cur)
          PosTempMsb: begin
            temp_word_d = {byte_i, 8'h00};
            crc_d       = crc8_feed(CrcInit, byte_i);
            pos_d       = PosTempLsb;
          end
          PosTempLsb: begin
            temp_word_d = {temp_word_q[15:8], byte_i};
            crc_d       = crc8_feed(crc_cur, byte_i);
            pos_d       = PosTempCrc;
          end
          PosTempCrc: begin
            temp_good_d = (crc_cur == byte_i);
            crc_d       = CrcInit;
            pos_d       = PosHumiMsb;
          end
          PosHumiMsb: begin
            humi_word_d = {byte_i, 8'h00};
            crc_d       = crc8_feed(CrcInit, byte_i);
            pos_d       = PosHumiLsb;
          end
          PosHumiLsb: begin
            humi_word_d = {humi_word_q[15:8], byte_i};
            crc_d       = crc8_feed(crc_cur, byte_i);
            pos_d       = PosHumiCrc;
          end
          PosHumiCrc: begin
            crc_d       = CrcInit;
            pos_d       = PosTempMsb;
            errs_d      = frame_good ? 8'd0 : errs_inc;
            res_valid_o = 1'b1;
          end
          default: begin
            pos_d = PosTempMsb;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempMsb;
      crc_q       <= CrcInit;
      temp_word_q <= 16'h0000;
      humi_word_q <= 16'h0000;
      temp_good_q <= 1'b0;
      errs_q      <= 8'd0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      humi_word_q <= humi_word_d;
      temp_good_q <= temp_good_d;
      errs_q      <= errs_d;
    end
  end

endmodule

/* hw/rtl/humidity_sensor_frame_checker.sv */
`timescale 1ns / 1ps
// Top level of the humidity sensor frame checker: input register, result
// register and error limit register. Uses hsfc_pkg, hsfc_frame.
//
// Takes one sensor byte or one bus fault per transfer (tuser = 1 marks a
// fault) and, on the sixth byte of a frame, gives one result with the raw
// temperature and humidity words, the converted values in hundredths, the
// CRC status in tuser (1 = mismatch) and the running error count. The block
// takes one transfer every cycle while the result register is not stalled;
// a result passes through the input register and then the result register,
// from which it is presented once the frame's last byte has been processed.
// A stalled result register holds further input in the input register.
// error_limit is written through cfg_we_i/cfg_wdata_i and resets to 50; when
// the error count has reached it, the next transfer first clears the count
// and restarts the frame.
module humidity_sensor_frame_checker
  import hsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] temp_sample, [31:16] humi_sample,
                                      // [46:32] temp_centi, [60:47] humi_centi,
                                      // [68:61] error_count, [71:69] zero
  output logic        m_axis_tuser    // [0] status
);

  logic         in_valid_q;
  logic         in_op_q;
  logic [7:0]   in_byte_q;
  logic [7:0]   limit_q;
  logic         proc_en;
  logic         res_valid;
  hsfc_result_t res;
  logic         out_valid_q;
  hsfc_result_t out_q;

  // an item moves on when the result slot is free or being drained
  assign proc_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_en;

  // error limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc_en) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  hsfc_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .proc_en_i     (proc_en),
    .op_i          (in_op_q),
    .byte_i        (in_byte_q),
    .error_limit_i (limit_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {3'b000, out_q.error_count, out_q.humi_centi,
                          out_q.temp_centi, out_q.humi_sample, out_q.temp_sample};

  // a new result only lands in a free or draining slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrites an untaken result");

  // a held input item is consumed whenever input is accepted into it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && in_valid_q) |-> proc_en)
    else $error("input accepted over an unprocessed item");

  // a frame with good crcs leaves the error count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatusGood)) |-> (out_q.error_count == 8'd0))
    else $error("good frame with nonzero error count");

  // humidity never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.humi_centi <= HumiMax))
    else $error("humidity above full scale");

endmodule

/* tb/sv/humidity_sensor_frame_checker_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for humidity_sensor_frame_checker: a directed table, then random
// sensor frames, faults and broken frames under several error limits, checked on a scoreboard.
// Depends on hsfc_pkg and humidity_sensor_frame_checker.
module humidity_sensor_frame_checker_tb;
  import hsfc_pkg::*;

  localparam int WatchLimit  = 4000;
  localparam int DrainCycles = 4;
  localparam int EndCycles   = 10;
  localparam int PhaseItems  = 45;
  localparam int DirRows     = 27;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = OpByte;
  logic        m_axis_tready = 1'b1;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  always #2 clk_i = ~clk_i;

  humidity_sensor_frame_checker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // how a crc byte in the directed table is filled in
  typedef enum logic [1:0] {
    CrcLit,
    CrcGood,
    CrcBad
  } crc_pick_e;

  typedef struct {
    logic      op;
    logic [7:0] data;
    crc_pick_e pick;
    int        want;   // index into known_res, -1 = use the predicted reading
  } dir_row_t;

  // readings that can be read off directly: zero frame, full-scale frame, bad temp crc
  hsfc_result_t known_res [3] = '{
    '{StatusGood, 16'h0000, 16'h0000, -15'sd4500, 14'd0,     8'd0},
    '{StatusGood, 16'hFFFF, 16'hFFFF, 15'sd13000, 14'd10000, 8'd0},
    '{StatusBad,  16'h0000, 16'hFFFF, -15'sd4500, 14'd10000, 8'd1}
  };

  dir_row_t dir_tab [DirRows] = '{
    // all-zero words, good crcs
    '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, -1},
    '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, 0},
    // full-scale words, good crcs
    '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, -1},
    '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, 1},
    // temperature crc mismatch
    '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcLit, -1}, '{OpByte, 8'h00, CrcBad, -1},
    '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'hFF, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, 2},
    // bus fault in the middle of a frame, its data byte ignored
    '{OpByte, 8'h12, CrcLit, -1}, '{OpByte, 8'h34, CrcLit, -1}, '{OpFault, 8'hA5, CrcLit, -1},
    // humidity crc mismatch
    '{OpByte, 8'h66, CrcLit, -1}, '{OpByte, 8'h9A, CrcLit, -1}, '{OpByte, 8'h00, CrcGood, -1},
    '{OpByte, 8'h12, CrcLit, -1}, '{OpByte, 8'h34, CrcLit, -1}, '{OpByte, 8'h00, CrcBad, -1}
  };

  // predictor state
  logic [7:0]  lim_q   = LimitReset;
  hsfc_pos_e   pos_q   = PosTempMsb;
  logic [7:0]  crc_q   = CrcInit;
  logic [15:0] tword_q = 16'h0000;
  logic [15:0] hword_q = 16'h0000;
  logic        tgood_q = 1'b0;
  logic [7:0]  errs_q  = 8'd0;

  hsfc_result_t readings_due [$];
  int mismatches   = 0;
  int stuck_cycles = 0;
  int burst_left   = 0;
  int gap_max      = 3;

  // sensor crc-8, one data bit at a time
  function automatic logic [7:0] sensor_crc(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic void bump_errors();
    if (errs_q != ErrMax) begin
      errs_q = errs_q + 8'd1;
    end
  endfunction

  // advance the frame tracker by one item; returns 1 when a reading is produced
  function automatic bit track_frame_byte(input logic op, input logic [7:0] b,
                                          output hsfc_result_t r);
    logic        hgood;
    int unsigned tc;
    int unsigned hc;
    r = '0;
    // limit reached: restart before handling this item
    if (errs_q >= lim_q) begin
      errs_q = 8'd0;
      pos_q  = PosTempMsb;
      crc_q  = CrcInit;
    end
    if (op == OpFault) begin
      bump_errors();
      pos_q = PosTempMsb;
      crc_q = CrcInit;
      return 1'b0;
    end
    case (pos_q)
      PosTempMsb: begin
        tword_q = {b, 8'h00};
        crc_q   = sensor_crc(CrcInit, b);
        pos_q   = PosTempLsb;
        return 1'b0;
      end
      PosTempLsb: begin
        tword_q[7:0] = b;
        crc_q        = sensor_crc(crc_q, b);
        pos_q        = PosTempCrc;
        return 1'b0;
      end
      PosTempCrc: begin
        tgood_q = (crc_q == b);
        crc_q   = CrcInit;
        pos_q   = PosHumiMsb;
        return 1'b0;
      end
      PosHumiMsb: begin
        hword_q = {b, 8'h00};
        crc_q   = sensor_crc(CrcInit, b);
        pos_q   = PosHumiLsb;
        return 1'b0;
      end
      PosHumiLsb: begin
        hword_q[7:0] = b;
        crc_q        = sensor_crc(crc_q, b);
        pos_q        = PosHumiCrc;
        return 1'b0;
      end
      default: begin
      end
    endcase
    // last byte of the frame: humidity crc, then the reading
    hgood = (crc_q == b);
    crc_q = CrcInit;
    pos_q = PosTempMsb;
    if (tgood_q && hgood) begin
      errs_q = 8'd0;
    end else begin
      bump_errors();
    end
    tc = tword_q;
    tc = (tc * 17500) / 65535;
    hc = hword_q;
    hc = (hc * 10000) / 65535;
    if (hc > 10000) begin
      hc = 10000;
    end
    r.status      = (tgood_q && hgood) ? StatusGood : StatusBad;
    r.temp_sample = tword_q;
    r.humi_sample = hword_q;
    r.temp_centi  = 15'(int'(tc) - 4500);
    r.humi_centi  = 14'(hc);
    r.error_count = errs_q;
    return 1'b1;
  endfunction

  // put one item on the input stream, with random gaps between bursts
  task automatic drive_item(input logic op, input logic [7:0] b);
    bit taken;
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    forever begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  task automatic feed(input logic op, input logic [7:0] b);
    hsfc_result_t r;
    if (track_frame_byte(op, b, r)) begin
      readings_due.push_back(r);
    end
    drive_item(op, b);
  endtask

  // a sensor frame, possibly cut short, with optional corrupted crcs
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input int nbytes,
                            input bit bad_t, input bit bad_h);
    logic [7:0] fr [6];
    fr[0] = tw[15:8];
    fr[1] = tw[7:0];
    fr[2] = sensor_crc(sensor_crc(CrcInit, tw[15:8]), tw[7:0])
            ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
    fr[3] = hw[15:8];
    fr[4] = hw[7:0];
    fr[5] = sensor_crc(sensor_crc(CrcInit, hw[15:8]), hw[7:0])
            ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int i = 0; i < nbytes; i++) begin
      feed(OpByte, fr[i]);
    end
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // stop sending and wait until every reading is back and the pipe is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_q = v;
  endtask

  task automatic report(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // receiver: periodic stall pattern, re-drawn every so often
  int rd_period = 1;
  int rd_stall  = 0;
  int rd_phase  = 0;
  int rd_left   = 0;
  always @(posedge clk_i) begin
    if (rd_left == 0) begin
      rd_left   = $urandom_range(20, 120);
      rd_period = $urandom_range(1, 16);
      rd_stall  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, rd_period - 1);
    end
    rd_left--;
    rd_phase = (rd_phase + 1) % rd_period;
    m_axis_tready <= (rd_phase >= rd_stall);
  end

  // scoreboard and watchdog, sampled mid-cycle ahead of the transfer edge
  always @(negedge clk_i) begin
    hsfc_result_t got;
    hsfc_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WatchLimit) begin
        $display("humidity_sensor_frame_checker regression: fail");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = m_axis_tuser;
        got.temp_sample = m_axis_tdata[15:0];
        got.humi_sample = m_axis_tdata[31:16];
        got.temp_centi  = m_axis_tdata[46:32];
        got.humi_centi  = m_axis_tdata[60:47];
        got.error_count = m_axis_tdata[68:61];
        if (readings_due.size() == 0) begin
          $display("%0t: reading with nothing pending, temp_sample %0d humi_sample %0d",
                   $time, got.temp_sample, got.humi_sample);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          report("status", want.status, got.status);
          report("temp_sample", want.temp_sample, got.temp_sample);
          report("humi_sample", want.humi_sample, got.humi_sample);
          report("temp_centi", $signed(want.temp_centi), $signed(got.temp_centi));
          report("humi_centi", want.humi_centi, got.humi_centi);
          report("error_count", want.error_count, got.error_count);
        end
      end
    end
  end

  // stimulus
  initial begin
    hsfc_result_t r;
    logic [7:0]   b;
    logic [7:0]   lim;
    int           n;
    int           k;
    int           cut;
    bit           paused;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset limit
    for (int i = 0; i < DirRows; i++) begin
      b = dir_tab[i].data;
      if (dir_tab[i].pick == CrcGood) begin
        b = crc_q;
      end else if (dir_tab[i].pick == CrcBad) begin
        b = crc_q ^ 8'h01;
      end
      if (track_frame_byte(dir_tab[i].op, b, r)) begin
        readings_due.push_back((dir_tab[i].want >= 0) ? known_res[dir_tab[i].want] : r);
      end
      drive_item(dir_tab[i].op, b);
    end

    // random phases, each under its own error limit
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0:       lim = 8'd1;
        1:       lim = ErrMax;
        2:       lim = 8'd2;
        3:       lim = 8'($urandom_range(3, 254));
        default: lim = LimitReset;
      endcase
      write_limit(lim);
      gap_max = (p == 3) ? 0 : 6;
      // run the count up to its ceiling and through the clear
      if (lim == ErrMax) begin
        repeat (256) feed(OpFault, 8'($urandom));
      end
      n = 0;
      paused = 1'b0;
      while (n < PhaseItems) begin
        if (n >= PhaseItems / 2 && !paused) begin
          paused = 1'b1;
          drain();
        end
        k = $urandom_range(0, 99);
        if (k < 70) begin
          send_frame(rand_word(), rand_word(), 6, ($urandom_range(0, 9) == 0),
                     ($urandom_range(0, 9) == 0));
          n += 6;
        end else if (k < 80) begin
          feed(OpFault, 8'($urandom));
          n++;
        end else if (k < 90) begin
          cut = $urandom_range(1, 5);
          send_frame(rand_word(), rand_word(), cut, 1'b0, 1'b0);
          n += cut;
        end else begin
          feed(($urandom_range(0, 1) == 1) ? OpFault : OpByte, 8'($urandom));
          n++;
        end
      end
    end

    drain();
    repeat (EndCycles) @(posedge clk_i);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("humidity_sensor_frame_checker regression: pass");
    end else begin
      $display("humidity_sensor_frame_checker regression: fail");
    end
    $finish;
  end

endmodule

/* humidity_sensor_frame_checker.f */
hw/rtl/hsfc_pkg.sv
hw/rtl/hsfc_conv.sv
hw/rtl/hsfc_frame.sv
hw/rtl/humidity_sensor_frame_checker.sv
tb/sv/humidity_sensor_frame_checker_tb.sv
